// File: src/mcce_pkg.sv
// Shared types, codes, constants and the microcode table of the matrix-chain cost evaluator.
`default_nettype none

package mcce_pkg;

    // Field widths of the item and result channels
    localparam int ACTION_W = 2;
    localparam int SYMBOL_W = 8;
    localparam int DIMIN_W  = 12;
    localparam int COST_W   = 48;
    localparam int STATUS_W = 2;

    // Defaults of the top-level parameters
    localparam int MCCE_STACK_DEPTH = 64;
    localparam int MCCE_DIM_BITS    = 12;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_DEFINE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CHAR   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EOL    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

    // Characters with a meaning of their own
    localparam logic [SYMBOL_W-1:0] CHAR_OPEN  = 8'h28;
    localparam logic [SYMBOL_W-1:0] CHAR_CLOSE = 8'h29;

    // Microprogram step addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] STEP_FETCH = 4'd0;
    localparam logic [UPC_W-1:0] STEP_DEF   = 4'd1;
    localparam logic [UPC_W-1:0] STEP_NAME0 = 4'd2;
    localparam logic [UPC_W-1:0] STEP_NAME1 = 4'd3;
    localparam logic [UPC_W-1:0] STEP_CL0   = 4'd4;
    localparam logic [UPC_W-1:0] STEP_CL1   = 4'd5;
    localparam logic [UPC_W-1:0] STEP_CL2   = 4'd6;
    localparam logic [UPC_W-1:0] STEP_CL3   = 4'd7;
    localparam logic [UPC_W-1:0] STEP_CL4   = 4'd8;
    localparam logic [UPC_W-1:0] STEP_CL5   = 4'd9;
    localparam logic [UPC_W-1:0] STEP_EOL0  = 4'd10;
    localparam logic [UPC_W-1:0] STEP_EOL1  = 4'd11;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_FETCH,
        OP_DEFINE,
        OP_CHK_FULL,
        OP_PUSH_TBL,
        OP_CHK_UNDER,
        OP_LOAD_A,
        OP_CHECK_B,
        OP_MUL1,
        OP_MUL2,
        OP_ACCUM_PUSH,
        OP_EMIT
    } op_t;

    // Jumps: true to target, else next step; dispatch: class entry on fire, else target
    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_FULL,
        J_UNDER,
        J_BAD,
        J_BUSY
    } jump_t;

    // Item classes for dispatch
    typedef enum logic [2:0] {
        CL_SKIP,
        CL_DEFINE,
        CL_NAME,
        CL_CLOSE,
        CL_EOL
    } item_class_t;

    typedef struct packed {
        op_t              op;
        jump_t            jc;
        logic [UPC_W-1:0] tgt;
    } ucode_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic        fire;
        item_class_t cls;
        logic        full;
        logic        under;
        logic        bad;
        logic        out_busy;
    } mcce_flags_t;

    // Control store
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NONE, jc: J_GOTO, tgt: STEP_FETCH};
        case (step)
            STEP_FETCH: w = '{op: OP_FETCH,      jc: J_DISPATCH, tgt: STEP_FETCH};
            STEP_DEF:   w = '{op: OP_DEFINE,     jc: J_GOTO,     tgt: STEP_FETCH};
            STEP_NAME0: w = '{op: OP_CHK_FULL,   jc: J_FULL,     tgt: STEP_FETCH};
            STEP_NAME1: w = '{op: OP_PUSH_TBL,   jc: J_GOTO,     tgt: STEP_FETCH};
            STEP_CL0:   w = '{op: OP_CHK_UNDER,  jc: J_UNDER,    tgt: STEP_FETCH};
            STEP_CL1:   w = '{op: OP_LOAD_A,     jc: J_NEXT,     tgt: STEP_FETCH};
            STEP_CL2:   w = '{op: OP_CHECK_B,    jc: J_BAD,      tgt: STEP_FETCH};
            STEP_CL3:   w = '{op: OP_MUL1,       jc: J_NEXT,     tgt: STEP_FETCH};
            STEP_CL4:   w = '{op: OP_MUL2,       jc: J_NEXT,     tgt: STEP_FETCH};
            STEP_CL5:   w = '{op: OP_ACCUM_PUSH, jc: J_GOTO,     tgt: STEP_FETCH};
            STEP_EOL0:  w = '{op: OP_EMIT,       jc: J_BUSY,     tgt: STEP_EOL0};
            STEP_EOL1:  w = '{op: OP_NONE,       jc: J_GOTO,     tgt: STEP_FETCH};
            default:    w = '{op: OP_NONE,       jc: J_GOTO,     tgt: STEP_FETCH};
        endcase
        return w;
    endfunction

    // Entry step for each item class
    function automatic logic [UPC_W-1:0] dispatch_step(input item_class_t cls);
        logic [UPC_W-1:0] s;
        case (cls)
            CL_DEFINE: s = STEP_DEF;
            CL_NAME:   s = STEP_NAME0;
            CL_CLOSE:  s = STEP_CL0;
            CL_EOL:    s = STEP_EOL0;
            default:   s = STEP_FETCH;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: src/mcce_item_if.sv
// Input item channel: one define, expression character or end of line per item.
`default_nettype none

interface mcce_item_if import mcce_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SYMBOL_W-1:0] symbol;
    logic [DIMIN_W-1:0]  rows;
    logic [DIMIN_W-1:0]  cols;

    modport source (output valid, action, symbol, rows, cols, input ready);
    modport sink   (input valid, action, symbol, rows, cols, output ready);
endinterface

`default_nettype wire

// File: src/mcce_result_if.sv
// Result channel: line cost and status.
`default_nettype none

interface mcce_result_if import mcce_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COST_W-1:0]   cost;
    logic [STATUS_W-1:0] status;

    modport source (output valid, cost, status, input ready);
    modport sink   (input valid, cost, status, output ready);
endinterface

`default_nettype wire

// File: src/matrix_chain_cost_evaluator_core.sv
// Top level of the matrix-chain cost evaluator: sequencer and datapath.
//
//   channel  dir  handshake      payload
//   expr     in   valid/ready    action[1:0] symbol[7:0] rows[11:0] cols[11:0]
//   result   out  valid/ready    cost[47:0] status[1:0]
//
// One item at a time; it is taken in the fetch step of the microprogram.
// An end of line waits for the result register to drain. A close reads its
// two operands in turn through the stack's single read port, then splits the
// product over two steps.
// Reset is asynchronous, active low; it marks every table entry undefined.
module matrix_chain_cost_evaluator_core import mcce_pkg::*;
#(
    parameter int STACK_DEPTH = MCCE_STACK_DEPTH,
    parameter int DIM_BITS    = MCCE_DIM_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    mcce_item_if.sink     expr,
    mcce_result_if.source result
);

    ucode_t      cw;
    mcce_flags_t flags;

    mcce_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    mcce_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH),
        .DIM_BITS    (DIM_BITS)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cw     (cw),
        .flags  (flags),
        .expr   (expr),
        .result (result)
    );

endmodule

`default_nettype wire

// File: src/mcce_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none

module mcce_sequencer import mcce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mcce_flags_t flags,
    output ucode_t           cw
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;

    // Look up the current control word
    assign cw = ucode_rom(upc_reg);

    // Select the next step
    always_comb
    begin
        upc_next = upc_reg + UPC_W'(1);
        case (cw.jc)
            J_NEXT:     upc_next = upc_reg + UPC_W'(1);
            J_GOTO:     upc_next = cw.tgt;
            J_DISPATCH: upc_next = flags.fire ? dispatch_step(flags.cls) : cw.tgt;
            J_FULL:     if (flags.full) upc_next = cw.tgt;
            J_UNDER:    if (flags.under) upc_next = cw.tgt;
            J_BAD:      if (flags.bad) upc_next = cw.tgt;
            J_BUSY:     if (flags.out_busy) upc_next = cw.tgt;
            default:    upc_next = STEP_FETCH;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// File: src/mcce_datapath.sv
// Datapath: dimension table, operand stack, multipliers, cost accumulator and result register.
`default_nettype none

module mcce_datapath import mcce_pkg::*;
#(
    parameter int STACK_DEPTH = MCCE_STACK_DEPTH,
    parameter int DIM_BITS    = MCCE_DIM_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ucode_t   cw,
    output mcce_flags_t   flags,
    mcce_item_if.sink     expr,
    mcce_result_if.source result
);

    localparam int SAW    = $clog2(STACK_DEPTH);
    localparam int LVLW   = $clog2(STACK_DEPTH + 1);
    localparam int PROD_W = 2 * DIM_BITS;
    localparam int TERM_W = 3 * DIM_BITS;
    localparam int SUM_W  = COST_W + 1;
    localparam int TBL_N  = 1 << SYMBOL_W;

    typedef struct packed {
        logic                v;
        logic [DIM_BITS-1:0] r;
        logic [DIM_BITS-1:0] c;
    } dims_t;

    // Memories
    logic [2*DIM_BITS-1:0] tbl_mem [TBL_N];
    dims_t                 stk_mem [STACK_DEPTH];

    // Control state
    logic [TBL_N-1:0]    tbl_vld_reg, tbl_vld_next;
    logic [LVLW-1:0]     level_reg, level_next;
    logic [COST_W-1:0]   cost_reg, cost_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    logic [SYMBOL_W-1:0]   sym_reg;
    logic [DIM_BITS-1:0]   rows_reg;
    logic [DIM_BITS-1:0]   cols_reg;
    logic [2*DIM_BITS-1:0] tbl_rd_reg;
    logic                  tbl_vld_rd_reg;
    dims_t                 stk_rd_reg;
    dims_t                 a_reg;
    dims_t                 b_reg;
    logic [PROD_W-1:0]     mul1_reg;
    logic [TERM_W-1:0]     mul2_reg;
    logic [COST_W-1:0]     out_cost_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic                  fire;
    logic                  out_busy;
    logic                  emit;
    logic                  stk_we;
    logic [SAW-1:0]        stk_waddr;
    dims_t                 stk_wdata;
    logic [SAW-1:0]        stk_raddr;
    logic [LVLW-1:0]       rd_level;
    logic [SUM_W-1:0]      sum;
    item_class_t           cls;

    // Handshakes
    assign expr.ready    = (cw.op == OP_FETCH);
    assign fire          = expr.valid && expr.ready;
    assign out_busy      = out_valid_reg && !result.ready;
    assign emit          = (cw.op == OP_EMIT) && !out_busy;
    assign result.valid  = out_valid_reg;
    assign result.cost   = out_cost_reg;
    assign result.status = out_status_reg;

    // Classify the incoming item
    always_comb
    begin
        cls = CL_SKIP;
        case (expr.action)
            ACT_DEFINE: cls = CL_DEFINE;
            ACT_CHAR:
            begin
                if (status_reg != ST_OK || expr.symbol == CHAR_OPEN)
                    cls = CL_SKIP;
                else if (expr.symbol == CHAR_CLOSE)
                    cls = CL_CLOSE;
                else
                    cls = CL_NAME;
            end
            ACT_EOL:    cls = CL_EOL;
            default:    cls = CL_SKIP;
        endcase
    end

    // Flags for the sequencer
    assign flags.fire     = fire;
    assign flags.cls      = cls;
    assign flags.full     = (level_reg == LVLW'(STACK_DEPTH));
    assign flags.under    = (level_reg < LVLW'(2));
    assign flags.bad      = !a_reg.v || !stk_rd_reg.v || (stk_rd_reg.c != a_reg.r);
    assign flags.out_busy = out_busy;

    // Stack read address: top for the right operand, one below for the left
    assign rd_level  = level_reg - ((cw.op == OP_LOAD_A) ? LVLW'(2) : LVLW'(1));
    assign stk_raddr = rd_level[SAW-1:0];
    assign stk_waddr = level_reg[SAW-1:0];

    // Sum of the running cost and the new term, one bit wider so the accumulation can saturate
    assign sum = SUM_W'(cost_reg) + SUM_W'(mul2_reg);

    // Next state of the line and the stack
    always_comb
    begin
        tbl_vld_next   = tbl_vld_reg;
        level_next     = level_reg;
        cost_next      = cost_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !result.ready;
        stk_we         = 1'b0;
        stk_wdata      = '{v: tbl_vld_rd_reg, r: tbl_rd_reg[2*DIM_BITS-1:DIM_BITS],
                           c: tbl_rd_reg[DIM_BITS-1:0]};
        case (cw.op)
            OP_DEFINE:
            begin
                tbl_vld_next[sym_reg] = 1'b1;
            end
            OP_CHK_FULL:
            begin
                if (flags.full)
                    status_next = ST_MALFORMED;
            end
            OP_PUSH_TBL:
            begin
                stk_we     = 1'b1;
                level_next = level_reg + LVLW'(1);
            end
            OP_CHK_UNDER:
            begin
                if (flags.under)
                    status_next = ST_MALFORMED;
            end
            OP_CHECK_B:
            begin
                level_next = level_reg - LVLW'(2);
                if (flags.bad)
                    status_next = ST_MISMATCH;
            end
            OP_ACCUM_PUSH:
            begin
                cost_next  = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
                stk_we     = 1'b1;
                stk_wdata  = '{v: 1'b1, r: b_reg.r, c: a_reg.c};
                level_next = level_reg + LVLW'(1);
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    level_next     = '0;
                    cost_next      = '0;
                    status_next    = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_vld_reg   <= '0;
            level_reg     <= '0;
            cost_reg      <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tbl_vld_reg   <= tbl_vld_next;
            level_reg     <= level_next;
            cost_reg      <= cost_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: latch item, operands, products and result
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sym_reg  <= expr.symbol;
            rows_reg <= DIM_BITS'(expr.rows);
            cols_reg <= DIM_BITS'(expr.cols);
        end
        tbl_vld_rd_reg <= tbl_vld_reg[sym_reg];
        if (cw.op == OP_LOAD_A)
            a_reg <= stk_rd_reg;
        if (cw.op == OP_CHECK_B)
            b_reg <= stk_rd_reg;
        if (cw.op == OP_MUL1)
            mul1_reg <= PROD_W'(b_reg.r) * PROD_W'(b_reg.c);
        if (cw.op == OP_MUL2)
            mul2_reg <= TERM_W'(mul1_reg) * TERM_W'(a_reg.c);
        if (emit)
        begin
            out_cost_reg   <= (status_reg == ST_OK) ? cost_reg : '0;
            out_status_reg <= status_reg;
        end
    end

    // Dimension table memory
    always_ff @(posedge clk)
    begin
        if (cw.op == OP_DEFINE)
            tbl_mem[sym_reg] <= {rows_reg, cols_reg};
        tbl_rd_reg <= tbl_mem[sym_reg];
    end

    // Operand stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_rd_reg <= stk_mem[stk_raddr];
    end

endmodule

`default_nettype wire
